@@ hw/rtl/mlpsf_pkg.sv @@
// ----------------------------------------------------------------------------
// mlpsf_pkg: shared types and constants of the perceptron forward block
// Word layouts, operation and register codes, sequencer states, and the
// sigmoid table, built once at elaboration.
// ----------------------------------------------------------------------------
package mlpsf_pkg;

  // Operation codes of an input word
  localparam logic [1:0] OP_WRITE_FIRST  = 2'd0;
  localparam logic [1:0] OP_WRITE_SECOND = 2'd1;
  localparam logic [1:0] OP_FEED         = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] REG_HIDDEN_COUNT = 2'd1;
  localparam logic [1:0] REG_OUTPUT_COUNT = 2'd2;

  // Reset values of the registers
  localparam logic [3:0] INPUT_COUNT_RST  = 4'd8;
  localparam logic [4:0] HIDDEN_COUNT_RST = 5'd16;
  localparam logic [2:0] OUTPUT_COUNT_RST = 3'd4;

  // Accumulator width: 33-bit products, up to 16 terms, sign margin
  localparam int ACC_W = 40;

  // e^(-1/16) in Q32
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

  typedef struct packed {
    logic [1:0]         operation;
    logic [6:0]         position;
    logic signed [15:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0]  unit_index;
    logic [15:0] activation;
    logic        last_unit;
  } result_t;

  // Controls from the sequencer to the shared multiply-accumulate
  typedef struct packed {
    logic operand_valid;
    logic clear;
    logic sat_load;
    logic sat_second;
  } mac_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_L1_MAC,
    ST_L1_DRAIN,
    ST_L1_SAT,
    ST_L1_ACT,
    ST_L2_MAC,
    ST_L2_DRAIN,
    ST_L2_SAT,
    ST_L2_ACT
  } state_t;

  // Rounded ratio floor((2*num + den) / (2*den)), by shift and subtract
  function automatic logic [63:0] round_ratio(input logic [63:0] num,
                                              input logic [63:0] den);
    logic [63:0] n2;
    logic [64:0] d2;
    logic [64:0] r;
    logic [63:0] q;
    n2 = (num << 1) + den;
    d2 = {den, 1'b0};
    r  = '0;
    q  = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n2[b]};
      if (r >= d2) begin
        r    = r - d2;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid over [-8, 8) in 256 steps; entry i stands for (i - 128) / 16
  function automatic logic [255:0][15:0] build_sig_table();
    logic [255:0][15:0] t;
    logic [63:0]        e;
    logic [63:0]        one;
    logic [63:0]        num_pos;
    one     = 64'd1 << 32;
    num_pos = 64'd65535 << 32;
    e       = one;
    t       = '0;
    t[128]  = 16'(round_ratio(num_pos, one + e));
    for (int k = 1; k <= 128; k++) begin
      e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
      if (k <= 127) begin
        t[128 + k] = 16'(round_ratio(num_pos, one + e));
      end
      t[128 - k] = 16'(round_ratio(64'd65535 * e, one + e));
    end
    return t;
  endfunction

  localparam logic [255:0][15:0] SIG_TABLE = build_sig_table();

endpackage

@@ hw/rtl/mlpsf_mac.sv @@
// ----------------------------------------------------------------------------
// mlpsf_mac: shared multiply-accumulate with scale and saturate
// One signed 17x16 product per cycle into a wide accumulator; on request the
// sum is floored to Q4.12 and clamped to [-8, 8).
// ----------------------------------------------------------------------------
module mlpsf_mac (
  input  logic                      clk,
  input  logic                      rst,
  input  mlpsf_pkg::mac_ctl_t       ctl,
  input  logic signed [16:0]        opa,
  input  logic signed [15:0]        opb,
  output logic                      busy,
  output logic signed [15:0]        z
);
  import mlpsf_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

  logic signed [32:0]      prod;
  logic                    prod_valid;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] scaled;
  logic signed [15:0]      z_next;

  // Register each product before it is summed
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.operand_valid;
    end
    if (ctl.operand_valid) begin
      prod <= opa * opb;
    end
  end

  // Accumulate, or clear for the next unit
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Floor-shift to Q4.12 and clamp
  always_comb begin
    scaled = ctl.sat_second ? (acc >>> 16) : (acc >>> 12);
    priority if (scaled > SAT_HI) begin
      z_next = 16'sh7fff;
    end else if (scaled < SAT_LO) begin
      z_next = -16'sh8000;
    end else begin
      z_next = scaled[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sat_load) begin
      z <= z_next;
    end
  end

  assign busy = prod_valid;

endmodule

@@ hw/rtl/mlp_sigmoid_forward_top.sv @@
// ----------------------------------------------------------------------------
// mlp_sigmoid_forward_top: two-layer perceptron inference with sigmoid
// Loads weights and features word by word; the final feature runs a pass
// through one shared multiply-accumulate and streams the output activations.
// ----------------------------------------------------------------------------
// Weight writes and non-final features are taken whenever the block is idle.
// A pass runs after the final feature over the counts N, H and O in use;
// each product goes through the single shared multiplier, one per cycle,
// and each unit then passes through read, drain, clamp and table lookup.
// No word is taken during a pass.
// Reset returns control to idle and loads the counts with 8, 16 and 4; weight,
// feature and hidden stores hold unknown data until written.
module mlp_sigmoid_forward_top #(
  parameter int MAX_INPUTS  = 8,
  parameter int MAX_HIDDEN  = 16,
  parameter int MAX_OUTPUTS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  mlpsf_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_stall,
  output mlpsf_pkg::result_t  result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mlpsf_pkg::*;

  localparam int W1_DEPTH = MAX_INPUTS * MAX_HIDDEN;
  localparam int W2_DEPTH = MAX_HIDDEN * MAX_OUTPUTS;
  localparam int W1_AW    = (W1_DEPTH > 1) ? $clog2(W1_DEPTH) : 1;
  localparam int W2_AW    = (W2_DEPTH > 1) ? $clog2(W2_DEPTH) : 1;
  localparam int F_AW     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int H_AW     = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int MAX_IH   = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN;
  localparam int MAX_ALL  = (MAX_IH > MAX_OUTPUTS) ? MAX_IH : MAX_OUTPUTS;
  localparam int IDX_W    = $clog2(MAX_ALL + 1);

  // Configuration registers
  logic [3:0] input_count;
  logic [4:0] hidden_count;
  logic [2:0] output_count;
  logic       cfg_write;

  // Stores
  logic signed [15:0] w1_mem [W1_DEPTH];
  logic signed [15:0] w2_mem [W2_DEPTH];
  logic signed [15:0] f_mem  [MAX_INPUTS];
  logic [15:0]        h_mem  [MAX_HIDDEN];

  logic signed [15:0] w1_rd;
  logic signed [15:0] w2_rd;
  logic signed [15:0] f_rd;
  logic [15:0]        h_rd;
  logic               rd_valid;
  logic               rd_second;

  // Sequencer
  state_t             state;
  state_t             state_next;
  logic [IDX_W-1:0]   i;
  logic [IDX_W-1:0]   j;
  logic [IDX_W-1:0]   n_in;
  logic [IDX_W-1:0]   n_hid;
  logic [IDX_W-1:0]   n_out;
  logic               accept;
  logic               start;
  logic               i_last;
  logic               j_last;
  logic               out_free;
  logic               issue;
  logic               issue_second;
  logic               h_we;
  logic               out_load;
  mac_ctl_t           mac_ctl;
  logic               mac_busy;
  logic signed [15:0] z;
  logic [15:0]        act;
  logic [W1_AW-1:0]   w1_raddr;
  logic [W2_AW-1:0]   w2_raddr;
  logic signed [16:0] opa;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count  <= INPUT_COUNT_RST;
      hidden_count <= HIDDEN_COUNT_RST;
      output_count <= OUTPUT_COUNT_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_INPUT_COUNT:  input_count  <= pwdata[3:0];
        REG_HIDDEN_COUNT: hidden_count <= pwdata[4:0];
        REG_OUTPUT_COUNT: output_count <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_INPUT_COUNT:  prdata = 32'(input_count);
      REG_HIDDEN_COUNT: prdata = 32'(hidden_count);
      REG_OUTPUT_COUNT: prdata = 32'(output_count);
      default:          prdata = '0;
    endcase
  end

  // Clamp the counts to 1..MAX
  always_comb begin
    if (input_count == '0) begin
      n_in = IDX_W'(1);
    end else if (32'(input_count) > MAX_INPUTS) begin
      n_in = IDX_W'(MAX_INPUTS);
    end else begin
      n_in = IDX_W'(input_count);
    end
    if (hidden_count == '0) begin
      n_hid = IDX_W'(1);
    end else if (32'(hidden_count) > MAX_HIDDEN) begin
      n_hid = IDX_W'(MAX_HIDDEN);
    end else begin
      n_hid = IDX_W'(hidden_count);
    end
    if (output_count == '0) begin
      n_out = IDX_W'(1);
    end else if (32'(output_count) > MAX_OUTPUTS) begin
      n_out = IDX_W'(MAX_OUTPUTS);
    end else begin
      n_out = IDX_W'(output_count);
    end
  end

  // Input handshake; the final feature starts a pass
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid & ~item_stall;
  assign start      = accept && (item.operation == OP_FEED)
                      && (32'(item.position) < MAX_INPUTS)
                      && (32'(item.position) == 32'(n_in) - 32'd1);

  // Weight and feature writes
  always_ff @(posedge clk) begin
    if (accept && (item.operation == OP_WRITE_FIRST)
        && (32'(item.position) < W1_DEPTH)) begin
      w1_mem[W1_AW'(item.position)] <= item.value;
    end
    if (accept && (item.operation == OP_WRITE_SECOND)
        && (32'(item.position) < W2_DEPTH)) begin
      w2_mem[W2_AW'(item.position)] <= item.value;
    end
    if (accept && (item.operation == OP_FEED)
        && (32'(item.position) < MAX_INPUTS)) begin
      f_mem[F_AW'(item.position)] <= item.value;
    end
    if (h_we) begin
      h_mem[j[H_AW-1:0]] <= act;
    end
  end

  // Operand addresses: row i, column j
  assign w1_raddr = W1_AW'(32'(i) * MAX_HIDDEN + 32'(j));
  assign w2_raddr = W2_AW'(32'(i) * MAX_OUTPUTS + 32'(j));

  // Read operands, registered
  always_ff @(posedge clk) begin
    w1_rd <= w1_mem[w1_raddr];
    w2_rd <= w2_mem[w2_raddr];
    f_rd  <= f_mem[i[F_AW-1:0]];
    h_rd  <= h_mem[i[H_AW-1:0]];
    rd_second <= issue_second;
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
  end

  assign opa = rd_second ? $signed({1'b0, h_rd}) : 17'(f_rd);

  mlpsf_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .opa  (opa),
    .opb  (rd_second ? w2_rd : w1_rd),
    .busy (mac_busy),
    .z    (z)
  );

  // Sigmoid lookup: index is (z + 32768) >> 8
  assign act = SIG_TABLE[{~z[15], z[14:8]}];

  assign i_last   = (state == ST_L1_MAC) ? (i == n_in - IDX_W'(1))
                                         : (i == n_hid - IDX_W'(1));
  assign j_last   = (state == ST_L1_ACT) ? (j == n_hid - IDX_W'(1))
                                         : (j == n_out - IDX_W'(1));
  assign out_free = ~result_valid | ~result_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_L1_MAC;
      end
      ST_L1_MAC: begin
        if (i_last) state_next = ST_L1_DRAIN;
      end
      ST_L1_DRAIN: begin
        if (!rd_valid && !mac_busy) state_next = ST_L1_SAT;
      end
      ST_L1_SAT: state_next = ST_L1_ACT;
      ST_L1_ACT: begin
        state_next = j_last ? ST_L2_MAC : ST_L1_MAC;
      end
      ST_L2_MAC: begin
        if (i_last) state_next = ST_L2_DRAIN;
      end
      ST_L2_DRAIN: begin
        if (!rd_valid && !mac_busy) state_next = ST_L2_SAT;
      end
      ST_L2_SAT: state_next = ST_L2_ACT;
      ST_L2_ACT: begin
        if (out_free) state_next = j_last ? ST_IDLE : ST_L2_MAC;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    issue                  = 1'b0;
    issue_second           = 1'b0;
    h_we                   = 1'b0;
    out_load               = 1'b0;
    mac_ctl.operand_valid  = rd_valid;
    mac_ctl.clear          = 1'b0;
    mac_ctl.sat_load       = 1'b0;
    mac_ctl.sat_second     = 1'b0;
    unique case (state)
      ST_IDLE:     mac_ctl.clear = 1'b1;
      ST_L1_MAC:   issue = 1'b1;
      ST_L1_DRAIN: ;
      ST_L1_SAT:   mac_ctl.sat_load = 1'b1;
      ST_L1_ACT: begin
        h_we          = 1'b1;
        mac_ctl.clear = 1'b1;
      end
      ST_L2_MAC: begin
        issue        = 1'b1;
        issue_second = 1'b1;
      end
      ST_L2_DRAIN: ;
      ST_L2_SAT: begin
        mac_ctl.sat_load   = 1'b1;
        mac_ctl.sat_second = 1'b1;
      end
      ST_L2_ACT: begin
        out_load      = out_free;
        mac_ctl.clear = 1'b1;
      end
      default: ;
    endcase
  end

  // State and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      if (issue) begin
        i <= i_last ? '0 : i + IDX_W'(1);
      end
      if (h_we || out_load) begin
        j <= j_last ? '0 : j + IDX_W'(1);
      end
    end
  end

  // Result register; hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (out_load) begin
      result.unit_index <= j[1:0];
      result.activation <= act;
      result.last_unit  <= j_last;
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the two-layer sigmoid perceptron
// Loads weights and features word by word, runs forward passes under random
// sender and receiver idling, and compares every output activation word with
// a predictor kept in the scoreboard. Counts are reprogrammed between phases.
// ----------------------------------------------------------------------------
import mlpsf_pkg::*;

class mlp_activation_scoreboard;
  localparam int IN_MAX  = 8;
  localparam int HID_MAX = 16;
  localparam int OUT_MAX = 4;
  localparam longint unsigned EXP_DECAY_Q32 = 64'd4034748382;

  shortint   first_w[IN_MAX*HID_MAX];
  shortint   second_w[HID_MAX*OUT_MAX];
  shortint   features[IN_MAX];
  bit [15:0] hidden[HID_MAX];
  bit [15:0] sig_lut[256];
  bit [3:0]  in_reg;
  bit [4:0]  hid_reg;
  bit [2:0]  out_reg;
  result_t   expected_outputs[$];
  int        faults;

  // Build the sigmoid table from the e^(-k/16) recurrence; load reset counts
  function new();
    longint unsigned e;
    longint unsigned one_q32;
    one_q32 = 64'd1 << 32;
    e = one_q32;
    sig_lut[128] = round_div(64'd65535 << 32, one_q32 + e);
    for (int k = 1; k <= 128; k++) begin
      e = (e * EXP_DECAY_Q32 + (64'd1 << 31)) >> 32;
      if (k <= 127) begin
        sig_lut[128 + k] = round_div(64'd65535 << 32, one_q32 + e);
      end
      sig_lut[128 - k] = round_div(64'd65535 * e, one_q32 + e);
    end
    in_reg  = 4'd8;
    hid_reg = 5'd16;
    out_reg = 3'd4;
    faults  = 0;
  endfunction

  function bit [15:0] round_div(longint unsigned num, longint unsigned den);
    return 16'((2 * num + den) / (2 * den));
  endfunction

  // Zero counts as one, anything above the maximum as the maximum
  function int clamp(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Floor shift, then saturate to [-8, 8) in Q4.12
  function int narrow(longint acc, int sh);
    longint q;
    q = acc >>> sh;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  function bit [15:0] squash(int z);
    return sig_lut[(z + 32768) >> 8];
  endfunction

  function int inputs_in_use();
    return clamp(in_reg, IN_MAX);
  endfunction

  function void set_register(logic [1:0] idx, logic [31:0] data);
    case (idx)
      REG_INPUT_COUNT:  in_reg  = data[3:0];
      REG_HIDDEN_COUNT: hid_reg = data[4:0];
      REG_OUTPUT_COUNT: out_reg = data[2:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] reg_value(logic [1:0] idx);
    case (idx)
      REG_INPUT_COUNT:  return {28'd0, in_reg};
      REG_HIDDEN_COUNT: return {27'd0, hid_reg};
      default:          return {29'd0, out_reg};
    endcase
  endfunction

  // Run both layers and queue one activation word per output unit
  function void forward_pass(int ni);
    int      nh;
    int      no;
    longint  acc;
    result_t r;
    nh = clamp(hid_reg, HID_MAX);
    no = clamp(out_reg, OUT_MAX);
    for (int j = 0; j < nh; j++) begin
      acc = 0;
      for (int i = 0; i < ni; i++) begin
        acc += longint'(features[i]) * longint'(first_w[i*HID_MAX + j]);
      end
      hidden[j] = squash(narrow(acc, 12));
    end
    for (int k = 0; k < no; k++) begin
      acc = 0;
      for (int j = 0; j < nh; j++) begin
        acc += longint'(hidden[j]) * longint'(second_w[j*OUT_MAX + k]);
      end
      r.unit_index = 2'(k);
      r.activation = squash(narrow(acc, 16));
      r.last_unit  = (k == no - 1);
      expected_outputs.push_back(r);
    end
  endfunction

  // Apply one accepted input word
  function void note_word(item_t w);
    int ni;
    case (w.operation)
      OP_WRITE_FIRST: first_w[w.position] = w.value;
      OP_WRITE_SECOND: begin
        if (w.position < HID_MAX*OUT_MAX) second_w[w.position] = w.value;
      end
      OP_FEED: begin
        if (w.position < IN_MAX) begin
          features[w.position] = w.value;
          ni = inputs_in_use();
          if (w.position == ni - 1) forward_pass(ni);
        end
      end
      default: ;
    endcase
  endfunction

  // Compare one accepted result word with the oldest expected activation
  function void check_output(result_t got);
    result_t want;
    if (expected_outputs.size() == 0) begin
      $error("result word with none expected: unit_index %0d activation %0d last_unit %0d",
             got.unit_index, got.activation, got.last_unit);
      faults++;
      return;
    end
    want = expected_outputs.pop_front();
    if (got.unit_index !== want.unit_index) begin
      $error("unit_index: expected %0d, got %0d", want.unit_index, got.unit_index);
      faults++;
    end
    if (got.activation !== want.activation) begin
      $error("activation: expected %0d, got %0d", want.activation, got.activation);
      faults++;
    end
    if (got.last_unit !== want.last_unit) begin
      $error("last_unit: expected %0d, got %0d", want.last_unit, got.last_unit);
      faults++;
    end
  endfunction

  function int pending();
    return expected_outputs.size();
  endfunction

  function void flag_leftover();
    if (expected_outputs.size() != 0) begin
      $error("%0d activation words never arrived", expected_outputs.size());
      faults++;
    end
  endfunction
endclass

module tb;
  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         WORD_TARGET   = 330;
  localparam int         SETTLE_CYCLES = 16;
  localparam int         DRAIN_LIMIT   = 20000;
  localparam int         PRESSURE_HOLD = 1500;

  logic        clk;
  logic        rst = 1'b1;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mlp_activation_scoreboard sb;
  int tx_mode;
  int rx_mode;
  int long_hold;
  int words_sent;
  int phase;

  mlp_sigmoid_forward_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin : watchdog
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  // Mode 0: no idling, 1: gaps drawn uniformly, 2: mostly back to back
  function automatic int draw_gap(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 17);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    endcase
  endfunction

  // Extremes, full-range noise, and small values that land mid-table
  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3, 4: return 16'($urandom);
      default: return 16'($urandom_range(0, 4095)) - 16'd2048;
    endcase
  endfunction

  function automatic int pick_count(int hi, int reg_max);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(hi + 1, reg_max);
      2:       return hi;
      3:       return 1;
      default: return $urandom_range(1, hi);
    endcase
  endfunction

  // Note accepted words on both channels
  always @(posedge clk) begin
    if (!rst && item_valid === 1'b1 && item_stall === 1'b0) sb.note_word(item);
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) sb.check_output(result);
  end

  // Result side: stall a drawn number of cycles before each word
  initial begin : result_sink
    int hold;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold > 0) begin
        hold = long_hold;
        long_hold = 0;
      end else begin
        hold = draw_gap(rx_mode);
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid === 1'b1 && result_stall === 1'b0));
    end
  end

  // Offer one word after a drawn gap and hold it until accepted
  task automatic send_word(input logic [1:0] op, input int pos, input logic [15:0] val);
    int    gap;
    item_t w;
    gap = draw_gap(tx_mode);
    w.operation = op;
    w.position  = 7'(pos);
    w.value     = val;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    do @(posedge clk); while (!(item_valid === 1'b1 && item_stall === 1'b0));
    words_sent++;
  endtask

  // Drop valid, wait for every expected word, then let the block go quiet
  task automatic settle_idle();
    int guard;
    guard = 0;
    item_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (sb.pending() > 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_register(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_verify(input logic [1:0] idx, input string name);
    logic [31:0] want;
    want = sb.reg_value(idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want) begin
      $error("%s: expected %0d, got %0d", name, want, prdata);
      sb.faults++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_counts();
    reg_verify(REG_INPUT_COUNT, "input_count");
    reg_verify(REG_HIDDEN_COUNT, "hidden_count");
    reg_verify(REG_OUTPUT_COUNT, "output_count");
  endtask

  task automatic program_counts(input int ni, input int nh, input int no);
    reg_write(REG_INPUT_COUNT, ni);
    reg_write(REG_HIDDEN_COUNT, nh);
    reg_write(REG_OUTPUT_COUNT, no);
    verify_counts();
  endtask

  // Random weight updates, a feature sequence, some noise, then usually the final feature
  task automatic run_episode();
    int ni;
    ni = sb.inputs_in_use();
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 1) == 0) begin
        send_word(OP_WRITE_FIRST, $urandom_range(0, 127), rand_value());
      end else begin
        send_word(OP_WRITE_SECOND, ($urandom_range(0, 9) == 0) ? $urandom_range(64, 127) :
                  $urandom_range(0, 63), rand_value());
      end
    end
    for (int i = 0; i < ni - 1; i++) begin
      if ($urandom_range(0, 2) != 0) send_word(OP_FEED, i, rand_value());
    end
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0:       send_word(OP_UNUSED, $urandom_range(0, 127), 16'($urandom));
        1:       send_word(OP_FEED, $urandom_range(8, 127), rand_value());
        2:       send_word(OP_WRITE_SECOND, $urandom_range(64, 127), rand_value());
        default: send_word(OP_FEED, $urandom_range(0, 7), rand_value());
      endcase
    end
    // Leave some sequences broken: no final feature
    if ($urandom_range(0, 7) != 0) send_word(OP_FEED, ni - 1, rand_value());
  endtask

  initial begin : stimulus
    sb = new();
    item_valid   <= 1'b0;
    item         <= '0;
    result_stall <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    tx_mode   = 1;
    rx_mode   = 1;
    long_hold = 0;
    words_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    verify_counts();

    // Load every weight and feature at the reset counts; last feature runs a pass
    for (int p = 0; p < 128; p++) send_word(OP_WRITE_FIRST, p, rand_value());
    for (int p = 0; p < 64; p++) send_word(OP_WRITE_SECOND, p, rand_value());
    for (int p = 0; p < 8; p++) send_word(OP_FEED, p, rand_value());
    settle_idle();

    // One unit per layer: saturate both ways, hit both table ends and the midpoint
    tx_mode = 2;
    rx_mode = 2;
    program_counts(1, 1, 1);
    send_word(OP_WRITE_FIRST, 0, 16'h7FFF);
    send_word(OP_WRITE_SECOND, 0, 16'h7FFF);
    send_word(OP_FEED, 0, 16'h7FFF);
    send_word(OP_FEED, 0, 16'h8000);
    send_word(OP_WRITE_SECOND, 0, 16'h8000);
    send_word(OP_FEED, 0, 16'h7FFF);
    send_word(OP_WRITE_FIRST, 0, 16'h0000);
    send_word(OP_FEED, 0, 16'h8000);
    // Ignored words must not alias onto stored weights
    send_word(OP_UNUSED, 127, 16'hFFFF);
    send_word(OP_WRITE_SECOND, 64, 16'h8000);
    send_word(OP_WRITE_SECOND, 127, 16'h7FFF);
    send_word(OP_WRITE_FIRST, 127, 16'h8000);
    send_word(OP_FEED, 0, 16'h7FFF);
    settle_idle();

    // Zero counts act as one; non-final and out-of-range features
    program_counts(2, 0, 0);
    send_word(OP_FEED, 0, 16'h7FFF);
    send_word(OP_FEED, 8, 16'h8000);
    send_word(OP_FEED, 127, 16'h8000);
    send_word(OP_FEED, 1, 16'h8000);
    settle_idle();

    // Counts above the maximum act as the maximum
    program_counts(0, 31, 7);
    send_word(OP_FEED, 0, 16'h1000);
    settle_idle();
    program_counts(15, 3, 2);
    send_word(OP_FEED, 5, rand_value());
    send_word(OP_FEED, 7, rand_value());
    send_word(OP_FEED, 7, rand_value());
    settle_idle();

    // Random phases until enough words have gone in; the first one piles up results
    phase = 0;
    while (words_sent < WORD_TARGET) begin
      if (phase == 0) begin
        program_counts(8, 16, 4);
        tx_mode = 0;
        rx_mode = 2;
        long_hold = PRESSURE_HOLD;
      end else begin
        program_counts(pick_count(8, 15), pick_count(16, 31), pick_count(4, 7));
        tx_mode = $urandom_range(0, 2);
        rx_mode = $urandom_range(0, 2);
      end
      repeat ($urandom_range(2, 6)) run_episode();
      settle_idle();
      phase++;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.flag_leftover();
    if (sb.faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mlpsf_pkg.sv
hw/rtl/mlpsf_mac.sv
hw/rtl/mlp_sigmoid_forward_top.sv
verif/tb.sv
